@@ rtl/ssd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, constants and the segment table of the seven-segment scan
// driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned NumW      = 16;
  localparam int unsigned HoldW     = 16;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 4;
  localparam int unsigned EnW       = NumDigits;
  localparam int unsigned ScanW     = $clog2(NumDigits);
  localparam int unsigned PhaseW    = 4;
  localparam int unsigned SegW      = 8;

  localparam logic [NumW-1:0]  MaxShown     = 16'd9999;
  localparam logic [HoldW-1:0] HoldTicksRst = 16'd1000;
  localparam logic [EnW-1:0]   EnAllOff     = 4'hF;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e           mode;
    logic [NumW-1:0] number;
  } in_req_t;

  typedef struct packed {
    logic           serial_data;
    logic           shift_clock;
    logic [EnW-1:0] digit_enable_n;
  } out_req_t;

  typedef logic [NumDigits-1:0][DigitW-1:0] digits_t;

  // active-low segment code, bit 0 goes out first; out-of-range shows nine
  function automatic logic [SegW-1:0] seg_code(input logic [DigitW-1:0] d);
    logic [SegW-1:0] c;
    unique case (d)
      4'd0:    c = 8'h03;
      4'd1:    c = 8'h9F;
      4'd2:    c = 8'h25;
      4'd3:    c = 8'h0D;
      4'd4:    c = 8'h99;
      4'd5:    c = 8'h49;
      4'd6:    c = 8'h41;
      4'd7:    c = 8'h1F;
      4'd8:    c = 8'h01;
      default: c = 8'h09;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/ssd_split.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_split
// Saturates a number to 9999 and splits it into four decimal digits.
// ----------------------------------------------------------------------------
module ssd_split (
  input  logic [ssd_pkg::NumW-1:0] number_i,
  output ssd_pkg::digits_t         digits_o
);
  import ssd_pkg::*;

  logic [13:0] sat;
  logic [9:0]  rem_h;
  logic [6:0]  rem_t;
  logic [3:0]  d_th, d_hu, d_te;

  assign sat = (number_i > MaxShown) ? 14'(MaxShown) : number_i[13:0];

  // each decade: parallel compares against k*10^n, highest hit wins
  always_comb begin
    d_th  = '0;
    rem_h = sat[9:0];
    for (int k = 1; k < 10; k++) begin
      if (sat >= 14'(k * 1000)) begin
        d_th  = 4'(k);
        rem_h = 10'(sat - 14'(k * 1000));
      end
    end
  end

  always_comb begin
    d_hu  = '0;
    rem_t = rem_h[6:0];
    for (int k = 1; k < 10; k++) begin
      if (rem_h >= 10'(k * 100)) begin
        d_hu  = 4'(k);
        rem_t = 7'(rem_h - 10'(k * 100));
      end
    end
  end

  always_comb begin
    d_te = '0;
    for (int k = 1; k < 10; k++) begin
      if (rem_t >= 7'(k * 10)) begin
        d_te = 4'(k);
      end
    end
  end

  assign digits_o[0] = d_th;
  assign digits_o[1] = d_hu;
  assign digits_o[2] = d_te;
  assign digits_o[3] = 4'(rem_t - (7'(d_te) * 7'd10));

endmodule

@@ rtl/ssd_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_scan
// Digit store and scan sequencer: shift phase, hold counter, pin levels.
// ----------------------------------------------------------------------------
module ssd_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  ssd_pkg::in_req_t          req_i,
  input  ssd_pkg::digits_t          digits_i,
  input  logic [ssd_pkg::HoldW-1:0] hold_ticks_i,
  output ssd_pkg::out_req_t         res_o
);
  import ssd_pkg::*;

  digits_t           store_q;
  logic [ScanW-1:0]  scan_q, scan_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [HoldW-1:0]  cnt_q, cnt_d;
  logic              holding_q, holding_d;
  logic [SegW-1:0]   code;
  logic [EnW-1:0]    en_pat;
  logic [HoldW:0]    cnt_inc;
  logic              is_load;

  assign is_load = (req_i.mode == MODE_LOAD);
  assign code    = seg_code(store_q[scan_q]);
  assign en_pat  = holding_q ? ~(EnW'(1) << scan_q) : EnAllOff;
  assign cnt_inc = {1'b0, cnt_q} + (HoldW+1)'(1);

  always_comb begin
    scan_d    = scan_q;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    holding_d = holding_q;
    res_o     = '{serial_data: 1'b0, shift_clock: 1'b0, digit_enable_n: en_pat};
    if (!is_load) begin
      if (!holding_q) begin
        res_o.serial_data    = code[phase_q[PhaseW-1:1]];
        res_o.shift_clock    = ~phase_q[0];
        res_o.digit_enable_n = EnAllOff;
        if (&phase_q) begin
          phase_d   = '0;
          holding_d = 1'b1;
          cnt_d     = '0;
        end else begin
          phase_d = phase_q + PhaseW'(1);
        end
      end else begin
        res_o.serial_data = code[SegW-1];
        cnt_d             = cnt_inc[HoldW-1:0];
        // zero hold reads as one tick
        if (cnt_inc >= {1'b0, hold_ticks_i}) begin
          holding_d = 1'b0;
          cnt_d     = '0;
          scan_d    = scan_q + ScanW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q   <= {4'd4, 4'd3, 4'd2, 4'd1};
      scan_q    <= '0;
      phase_q   <= '0;
      cnt_q     <= '0;
      holding_q <= 1'b0;
    end else if (fire_i) begin
      if (is_load) begin
        store_q <= digits_i;
      end else begin
        scan_q    <= scan_d;
        phase_q   <= phase_d;
        cnt_q     <= cnt_d;
        holding_q <= holding_d;
      end
    end
  end

  a_phase_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    holding_q |-> phase_q == '0)
    else $error("shift phase not zero while holding");

  a_cnt_idle_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !holding_q |-> cnt_q == '0)
    else $error("hold count not zero while shifting");

  a_one_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(~res_o.digit_enable_n) <= 1)
    else $error("more than one digit enabled");

  a_clk_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.shift_clock |-> res_o.digit_enable_n == EnAllOff)
    else $error("digit lit while shifting");

endmodule

@@ rtl/seven_segment_serial_scan_driver_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_serial_scan_driver_core
// Four-digit multiplexed seven-segment driver feeding a serial-in shift
// register; load requests set the number, tick requests step the scan.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Carries
//  in      | input     | in_valid / stall   | mode, number (in_req_t)
//  out     | output    | out_valid / stall  | serial_data, shift_clock, enables
//  cfg     | input     | cfg_valid / ready  | hold_ticks
//
//  One request per clock unless out stalls; requests pass the input register,
//  then sequencer logic into the result register. Rate is set by the
//  single-pass sequencer step between the two registers. Reset (async, low):
//  digits 1 2 3 4, scan at digit 0, shifting, hold 1000. A stall on out holds
//  the result register and back-pressures in through the input register;
//  cfg is always ready; the user must write it only when idle (not enforced).
// ----------------------------------------------------------------------------
module seven_segment_serial_scan_driver_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  ssd_pkg::in_req_t          in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output ssd_pkg::out_req_t         out_req_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ssd_pkg::HoldW-1:0] cfg_data_i
);
  import ssd_pkg::*;

  // input register
  in_req_t          in_q;
  logic             in_vld_q;
  // result register
  out_req_t         out_q;
  logic             out_vld_q;
  // configuration
  logic [HoldW-1:0] hold_ticks_q;

  logic     adv;      // result register can take a new request
  logic     fire;     // request in the input register is processed
  digits_t  digits;
  out_req_t res;

  assign adv        = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= HoldTicksRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      hold_ticks_q <= cfg_data_i;
    end
  end

  // decimal split of the load value
  ssd_split u_split (
    .number_i (in_q.number),
    .digits_o (digits)
  );

  // store, scan sequencer and pin levels
  ssd_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .req_i        (in_q),
    .digits_i     (digits),
    .hold_ticks_i (hold_ticks_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;

endmodule

@@ test/tb_seven_segment_serial_scan_driver_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_segment_serial_scan_driver_core
// Self-checking bench for the serial scan driver. A directed table, then
// randomised load and tick requests over several hold settings. Every pin
// request out is checked against a local scan sequencer model or typed pins.
// ----------------------------------------------------------------------------
module tb_seven_segment_serial_scan_driver_core;
  import ssd_pkg::*;

  localparam int unsigned CycleLimit  = 250000;
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned NumVecs     = 23;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseItems  = 200;
  localparam int unsigned LongHoldOff = 80;

  // active-low segment codes, bit 0 goes out first
  localparam logic [SegW-1:0] SegTable [10] = '{
    8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99, 8'h49, 8'h41, 8'h1F, 8'h01, 8'h09
  };

  // directed row: typed pins are only checked as written when has_pins is set
  typedef struct packed {
    logic     has_pins;
    out_req_t pins;
    in_req_t  req;
  } vec_t;

  localparam vec_t DirectedVecs [NumVecs] = '{
    {1'b1, 1'b1, 1'b1, 4'hF, MODE_TICK, 16'hFFFF}, // digit 1 code, bit 0, clock high
    {1'b1, 1'b1, 1'b0, 4'hF, MODE_TICK, 16'h0000}, // same bit, clock low
    {1'b1, 1'b0, 1'b0, 4'hF, MODE_LOAD, 16'hFFFF}, // saturates, no step
    {1'b1, 1'b0, 1'b0, 4'hF, MODE_LOAD, 16'd10000},
    {1'b1, 1'b0, 1'b0, 4'hF, MODE_LOAD, 16'd0},    // rest of shift from new code
    {1'b0, 6'h00, MODE_TICK, 16'hAAAA},
    {1'b0, 6'h00, MODE_TICK, 16'h5555},
    {1'b0, 6'h00, MODE_TICK, 16'h8001},
    {1'b0, 6'h00, MODE_TICK, 16'h7FFE},
    {1'b0, 6'h00, MODE_TICK, 16'h00FF},
    {1'b0, 6'h00, MODE_TICK, 16'hFF00},
    {1'b0, 6'h00, MODE_TICK, 16'h0F0F},
    {1'b0, 6'h00, MODE_TICK, 16'hF0F0},
    {1'b0, 6'h00, MODE_TICK, 16'h3333},
    {1'b0, 6'h00, MODE_TICK, 16'hCCCC},
    {1'b0, 6'h00, MODE_TICK, 16'h1234},
    {1'b0, 6'h00, MODE_TICK, 16'h4321},
    {1'b0, 6'h00, MODE_TICK, 16'h0001},
    {1'b0, 6'h00, MODE_TICK, 16'h8000},            // last bit, now lit
    {1'b1, 1'b0, 1'b0, 4'hE, MODE_LOAD, 16'd9999}, // load while digit 0 lit
    {1'b0, 6'h00, MODE_TICK, 16'h0001},
    {1'b0, 6'h00, MODE_LOAD, 16'd1234},
    {1'b0, 6'h00, MODE_TICK, 16'd8000}
  };

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_req_t          in_req;
  logic             out_valid;
  logic             out_stall;
  out_req_t         out_req;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [HoldW-1:0] cfg_data;

  // scan sequencer model state
  logic [HoldW-1:0]  hold_ticks_m;
  logic [DigitW-1:0] digit_m [NumDigits];
  logic [ScanW-1:0]  scan_m;
  logic [PhaseW-1:0] phase_m;
  logic [HoldW:0]    hold_cnt_m;
  logic              holding_m;

  out_req_t    pending_pins [$];
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;

  // stimulus knobs; rx_idle_on and long_hold_req are shared with the receiver
  bit tx_idle_on    = 1'b1;
  bit rx_idle_on    = 1'b1;
  bit long_hold_req = 1'b0;

  seven_segment_serial_scan_driver_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_req_i     (in_req),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_req_o    (out_req),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // enables: lit digit low while holding, otherwise all off
  function automatic logic [EnW-1:0] lit_enables();
    return holding_m ? ~(4'b0001 << scan_m) : EnAllOff;
  endfunction

  // pin levels for one request; loads set model digits, ticks advance the sequencer
  function automatic out_req_t predict_pins(input in_req_t r);
    out_req_t        o;
    logic [NumW-1:0] n;
    logic [SegW-1:0] code;
    o = '0;
    if (r.mode == MODE_LOAD) begin
      n = (r.number > MaxShown) ? MaxShown : r.number;
      digit_m[0] = 4'(n / 1000);
      digit_m[1] = 4'((n % 1000) / 100);
      digit_m[2] = 4'((n % 100) / 10);
      digit_m[3] = 4'(n % 10);
      o.digit_enable_n = lit_enables();
      return o;
    end
    code = SegTable[digit_m[scan_m]];
    if (!holding_m) begin
      // even phase: data bit out, clock high; odd phase: clock low
      o.serial_data    = code[phase_m[3:1]];
      o.shift_clock    = ~phase_m[0];
      o.digit_enable_n = EnAllOff;
      if (phase_m == 4'd15) begin
        phase_m    = '0;
        holding_m  = 1'b1;
        hold_cnt_m = '0;
      end else begin
        phase_m = phase_m + 1'b1;
      end
    end else begin
      o.serial_data    = code[SegW-1];
      o.shift_clock    = 1'b0;
      o.digit_enable_n = lit_enables();
      hold_cnt_m       = hold_cnt_m + 1'b1;
      // a zero hold compares true at once, so the digit is lit one tick
      if (hold_cnt_m >= hold_ticks_m) begin
        holding_m  = 1'b0;
        hold_cnt_m = '0;
        scan_m     = scan_m + 1'b1;
      end
    end
    return o;
  endfunction

  // offer one request; valid is left high for a back-to-back follower
  task automatic send_request(input in_req_t r, input logic typed, input out_req_t typed_pins);
    out_req_t pins;
    @(negedge clk);
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    pins = predict_pins(r);
    pending_pins.push_back(typed ? typed_pins : pins);
  endtask

  task automatic pause_sender(input int unsigned k);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (k - 1) @(negedge clk);
  endtask

  task automatic drain_pins();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
  endtask

  task automatic write_hold(input logic [HoldW-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    hold_ticks_m = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_req_t random_request();
    in_req_t r;
    r.number = 16'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      r.mode = MODE_LOAD;
      case ($urandom_range(0, 5))
        0: r.number = 16'($urandom_range(0, 9999));
        1: r.number = 16'($urandom_range(10000, 65535));
        2: begin
          case ($urandom_range(0, 3))
            0:       r.number = 16'd0;
            1:       r.number = 16'd9999;
            2:       r.number = 16'd10000;
            default: r.number = 16'hFFFF;
          endcase
        end
        default: ;
      endcase
    end else begin
      r.mode = MODE_TICK;
    end
    return r;
  endfunction

  // one block of random requests at the current hold setting
  task automatic run_phase(input bit idling, input bit hold_off, input bit mid_drain);
    for (int unsigned i = 0; i < PhaseItems; i++) begin
      if (i % 40 == 0) begin
        tx_idle_on = idling && ($urandom_range(0, 2) != 0);
        rx_idle_on = idling && ($urandom_range(0, 2) != 0);
      end
      if (hold_off && i == PhaseItems / 3) long_hold_req = 1'b1;
      if (mid_drain && i == PhaseItems / 2) drain_pins();
      if (tx_idle_on && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 11));
      send_request(random_request(), 1'b0, '0);
    end
    drain_pins();
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LongHoldOff;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      out_stall <= (stall_left > 0);
    end
  end

  // result checker: oldest expectation against each accepted pin request
  always @(posedge clk) begin
    out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pin request: sd=%0b sc=%0b en=%h",
                   out_req.serial_data, out_req.shift_clock, out_req.digit_enable_n);
      end else begin
        want = pending_pins.pop_front();
        if (out_req.serial_data !== want.serial_data ||
            out_req.shift_clock !== want.shift_clock ||
            out_req.digit_enable_n !== want.digit_enable_n) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pin mismatch: want sd=%0b sc=%0b en=%h, got sd=%0b sc=%0b en=%h",
                     want.serial_data, want.shift_clock, want.digit_enable_n,
                     out_req.serial_data, out_req.shift_clock, out_req.digit_enable_n);
        end
      end
    end
  end

  initial begin
    logic [HoldW-1:0] hold_plan [NumPhases];
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;

    hold_ticks_m = HoldTicksRst;
    digit_m      = '{4'd1, 4'd2, 4'd3, 4'd4};
    scan_m       = '0;
    phase_m      = '0;
    hold_cnt_m   = '0;
    holding_m    = 1'b0;

    // extremes, the zero-hold case, the reset value and a few short holds
    hold_plan = '{16'd1, 16'd0, 16'($urandom_range(2, 40)), 16'hFFFF,
                  16'($urandom_range(2, 20)), HoldTicksRst, 16'd3,
                  16'($urandom_range(1, 12))};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table at the reset hold setting
    for (int unsigned v = 0; v < NumVecs; v++) begin
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 11));
      send_request(DirectedVecs[v].req, DirectedVecs[v].has_pins, DirectedVecs[v].pins);
    end
    drain_pins();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      write_hold(hold_plan[p]);
      run_phase(p != NumPhases - 1, p == 1, p == 2);
    end

    repeat (TailCycles) @(posedge clk);
    if (pending_pins.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
